[hw/rtl/causal_2d_iir_image_filter_macros.svh]
// Assertion macros shared by the causal 2D IIR filter RTL.
// Needs clk and rst_n in the scope of each use; empty when SYNTH is set.
`ifndef CAUSAL_2D_IIR_IMAGE_FILTER_MACROS_SVH
`define CAUSAL_2D_IIR_IMAGE_FILTER_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define C2D_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("c2d: same-cycle check failed");
// next-cycle implication
`define C2D_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("c2d: next-cycle check failed");
`else
`define C2D_ASSERT_IMP(label, ante, cons)
`define C2D_ASSERT_NXT(label, ante, cons)
`endif
`endif

[hw/rtl/c2d_pkg.sv]
// Shared types and constants for the causal 2D IIR image filter.
// No dependencies.
`timescale 1ns / 1ps

package c2d_pkg;

  localparam int unsigned PIX_W     = 8;
  localparam int unsigned LW_W      = 11;
  localparam int unsigned COEF_W    = 18;
  localparam int unsigned ST_W      = 32;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned CFG_IDX_W = 3;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_WIDTH  = 3'd0,
    REG_COEF_CENTER = 3'd1,
    REG_COEF_LEFT   = 3'd2,
    REG_COEF_UP     = 3'd3,
    REG_COEF_DIAG   = 3'd4
  } cfg_reg_t;

  // reset values (coefficients Q2.16)
  localparam logic [LW_W-1:0]   LINE_WIDTH_RST  = 11'd256;
  localparam logic [COEF_W-1:0] COEF_CENTER_RST = 18'd655;
  localparam logic [COEF_W-1:0] COEF_LEFT_RST   = 18'd58982;
  localparam logic [COEF_W-1:0] COEF_UP_RST     = 18'd58982;
  localparam logic [COEF_W-1:0] COEF_DIAG_RST   = 18'h3_30A4; // -53084

  localparam logic [PIX_W-1:0]  PIX_MAX = 8'd255;

  // configuration as seen by the datapath; coefficients are two's complement
  typedef struct packed {
    logic [LW_W-1:0]   line_width;
    logic [COEF_W-1:0] coef_center;
    logic [COEF_W-1:0] coef_left;
    logic [COEF_W-1:0] coef_up;
    logic [COEF_W-1:0] coef_diag;
  } c2d_cfg_t;

endpackage

[hw/rtl/c2d_if.sv]
// Valid/ready channel interfaces for pixel items in and out of the filter.
// Depends on c2d_pkg.
`timescale 1ns / 1ps

interface c2d_in_if import c2d_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] in_pixel;
  logic             frame_start;

  modport source (output valid, output in_pixel, output frame_start, input ready);
  modport sink   (input valid, input in_pixel, input frame_start, output ready);
endinterface

interface c2d_out_if import c2d_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] out_pixel;

  modport source (output valid, output out_pixel, input ready);
  modport sink   (input valid, input out_pixel, output ready);
endinterface

[hw/rtl/causal_2d_iir_image_filter.sv]
// Top level of the causal 2D IIR image filter.
// Depends on c2d_pkg, c2d_if, c2d_cfg_regs, c2d_core and the macro header.
`timescale 1ns / 1ps
`include "causal_2d_iir_image_filter_macros.svh"

// Filters one 8-bit plane in raster order, one pixel item per clock
// sustained while the output drains. Each item's result passes through
// one compute stage, then the output register. While a result waits, one more
// item can enter the compute stage; after that the input stalls until the
// result is taken. The rate is set by the left-neighbour feedback, which
// closes through the four parallel multipliers into left_r, and by the row
// store, a single-port-write / single-port-read memory of MAX_WIDTH words
// read at acceptance and written as the item leaves compute. A pixel that
// reads the entry its predecessor is writing (one-pixel rows) takes the value
// by forwarding. The row store needs no clearing pass after reset. Assert
// frame_start on the first pixel of each frame; write configuration only
// while idle.
module causal_2d_iir_image_filter import c2d_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  c2d_in_if.sink               in_if,
  c2d_out_if.source            out_if,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_wdata
);

  c2d_cfg_t         cfg;
  logic             core_vld;
  logic [PIX_W-1:0] core_pixel;
  logic             dn_ready;
  logic             out_vld_r;
  logic [PIX_W-1:0] out_pixel_r;

  c2d_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  c2d_core #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .in_valid    (in_if.valid),
    .in_pixel    (in_if.in_pixel),
    .frame_start (in_if.frame_start),
    .in_ready    (in_if.ready),
    .dn_ready    (dn_ready),
    .y_vld       (core_vld),
    .y_pixel     (core_pixel)
  );

  // output register: free when empty or being drained
  assign dn_ready = !out_vld_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (dn_ready) begin
      out_vld_r <= core_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (core_vld && dn_ready) begin
      out_pixel_r <= core_pixel;
    end
  end

  assign out_if.valid     = out_vld_r;
  assign out_if.out_pixel = out_pixel_r;

  // a finished item always lands in the output register
  `C2D_ASSERT_NXT(a_out_load, core_vld && dn_ready, out_vld_r)

endmodule

[hw/rtl/c2d_cfg_regs.sv]
// Configuration register bank: line width and the four Q2.16 coefficients.
// Depends on c2d_pkg.
`timescale 1ns / 1ps

module c2d_cfg_regs import c2d_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_wdata,
  output c2d_cfg_t             cfg
);

  c2d_cfg_t cfg_r;
  c2d_cfg_t cfg_nxt;

  // decode the write; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_LINE_WIDTH:  cfg_nxt.line_width  = cfg_wdata[LW_W-1:0];
        REG_COEF_CENTER: cfg_nxt.coef_center = cfg_wdata;
        REG_COEF_LEFT:   cfg_nxt.coef_left   = cfg_wdata;
        REG_COEF_UP:     cfg_nxt.coef_up     = cfg_wdata;
        REG_COEF_DIAG:   cfg_nxt.coef_diag   = cfg_wdata;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.line_width  <= LINE_WIDTH_RST;
      cfg_r.coef_center <= COEF_CENTER_RST;
      cfg_r.coef_left   <= COEF_LEFT_RST;
      cfg_r.coef_up     <= COEF_UP_RST;
      cfg_r.coef_diag   <= COEF_DIAG_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[hw/rtl/c2d_row_mem.sv]
// One-line store of full-precision outputs: one write port, one read port,
// registered read data. No dependencies.
`timescale 1ns / 1ps

module c2d_row_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port; a read of the entry being written returns the old data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/c2d_core.sv]
// Filter core: raster position tracking, row store access with forwarding,
// and the recurrence y = c*x + a*left + b*up + d*upleft.
// Depends on c2d_pkg, c2d_row_mem and the assertion macro header.
`timescale 1ns / 1ps
`include "causal_2d_iir_image_filter_macros.svh"

module c2d_core import c2d_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  c2d_cfg_t         cfg,
  input  logic             in_valid,
  input  logic [PIX_W-1:0] in_pixel,
  input  logic             frame_start,
  output logic             in_ready,
  input  logic             dn_ready,
  output logic             y_vld,
  output logic [PIX_W-1:0] y_pixel
);

  localparam int unsigned AW     = $clog2(MAX_WIDTH);
  localparam int unsigned CW     = (AW + 1 > LW_W) ? AW + 1 : LW_W;
  localparam int unsigned PC_W   = COEF_W + PIX_W + 1;
  localparam int unsigned PCS_W  = PC_W + FRAC_W;
  localparam int unsigned PS_W   = COEF_W + ST_W;
  localparam int unsigned ACC_W  = PS_W + 2;
  localparam int unsigned SH_W   = ACC_W - FRAC_W;

  // position state
  logic [AW-1:0] col_r, col_nxt;
  logic          first_r, first_nxt;

  // compute stage
  logic             s1_vld_r;
  logic [PIX_W-1:0] s1_x_r;
  logic [AW-1:0]    s1_col_r;
  logic             s1_first_r;
  logic             s1_fwd_r;

  logic signed [ST_W-1:0] left_r;
  logic signed [ST_W-1:0] upleft_r;

  logic          in_acc;
  logic          s1_adv;
  logic [AW-1:0] col_cur;
  logic          first_cur;
  logic [CW-1:0] width_ext;
  logic [CW-1:0] width_eff;
  logic          last_col;

  logic [ST_W-1:0]        rd_data;
  logic signed [ST_W-1:0] up_v;
  logic signed [ST_W-1:0] left_v;
  logic signed [ST_W-1:0] upl_v;
  logic signed [PC_W-1:0]  p_c;
  logic signed [PCS_W-1:0] p_cs;
  logic signed [PS_W-1:0]  p_a;
  logic signed [PS_W-1:0]  p_b;
  logic signed [PS_W-1:0]  p_d;
  logic signed [ACC_W-1:0] acc;
  logic signed [SH_W-1:0]  sh;
  logic signed [ST_W-1:0]  y;

  // handshake: a new item enters whenever the compute stage empties
  assign s1_adv   = s1_vld_r && dn_ready;
  assign in_ready = !s1_vld_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  // position of the incoming item; frame start restarts at the top left
  assign col_cur   = frame_start ? '0 : col_r;
  assign first_cur = frame_start || first_r;

  // effective width: zero acts as one, clamp to the store depth
  always_comb begin
    width_ext = CW'(cfg.line_width);
    if (width_ext == '0) begin
      width_eff = CW'(1);
    end else if (width_ext > CW'(MAX_WIDTH)) begin
      width_eff = CW'(MAX_WIDTH);
    end else begin
      width_eff = width_ext;
    end
  end

  assign last_col = (CW'(col_cur) + CW'(1)) >= width_eff;

  always_comb begin
    col_nxt   = col_r;
    first_nxt = first_r;
    if (in_acc) begin
      if (last_col) begin
        col_nxt   = '0;
        first_nxt = 1'b0;
      end else begin
        col_nxt   = col_cur + AW'(1);
        first_nxt = first_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      first_r <= 1'b1;
    end else begin
      col_r   <= col_nxt;
      first_r <= first_nxt;
    end
  end

  // stage register; forward flag marks a read that races the write of
  // the item ahead (one-pixel rows)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_x_r     <= in_pixel;
      s1_col_r   <= col_cur;
      s1_first_r <= first_cur;
      s1_fwd_r   <= s1_vld_r && (s1_col_r == col_cur);
    end
  end

  // row store: read at acceptance, written as the item leaves the stage
  c2d_row_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW),
    .DW    (ST_W)
  ) u_row_mem (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col_r),
    .wdata (y),
    .re    (in_acc),
    .raddr (col_cur),
    .rdata (rd_data)
  );

  // neighbours, zero outside the image
  always_comb begin
    if (s1_first_r) begin
      up_v = '0;
    end else if (s1_fwd_r) begin
      up_v = left_r;
    end else begin
      up_v = $signed(rd_data);
    end
    left_v = (s1_col_r == '0) ? '0 : left_r;
    upl_v  = (s1_first_r || (s1_col_r == '0)) ? '0 : upleft_r;
  end

  // four products in parallel, exact sum
  assign p_c  = $signed(cfg.coef_center) * $signed({1'b0, s1_x_r});
  assign p_cs = {p_c, {FRAC_W{1'b0}}};
  assign p_a  = $signed(cfg.coef_left) * left_v;
  assign p_b  = $signed(cfg.coef_up) * up_v;
  assign p_d  = $signed(cfg.coef_diag) * upl_v;
  assign acc  = ACC_W'(p_cs) + ACC_W'(p_a) + ACC_W'(p_b) + ACC_W'(p_d);

  // floor shift then saturate to Q16.16
  assign sh = acc[ACC_W-1:FRAC_W];
  always_comb begin
    if ((sh[SH_W-1:ST_W-1] == '0) || (sh[SH_W-1:ST_W-1] == '1)) begin
      y = sh[ST_W-1:0];
    end else if (sh[SH_W-1]) begin
      y = {1'b1, {(ST_W-1){1'b0}}};
    end else begin
      y = {1'b0, {(ST_W-1){1'b1}}};
    end
  end

  // feedback registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= '0;
      upleft_r <= '0;
    end else if (s1_adv) begin
      left_r   <= y;
      upleft_r <= up_v;
    end
  end

  // output pixel: integer part clamped to 0..255
  always_comb begin
    if (y[ST_W-1]) begin
      y_pixel = '0;
    end else if (|y[ST_W-2:FRAC_W+PIX_W]) begin
      y_pixel = PIX_MAX;
    end else begin
      y_pixel = y[FRAC_W+PIX_W-1:FRAC_W];
    end
  end

  assign y_vld = s1_vld_r;

  // forwarding only happens at column 0, as on one-pixel rows
  `C2D_ASSERT_IMP(a_fwd_col0, s1_vld_r && s1_fwd_r, s1_col_r == '0)
  // frame start lands at the top left
  `C2D_ASSERT_NXT(a_frame_pos, in_acc && frame_start, s1_vld_r && s1_first_r && (s1_col_r == '0))
  // an item never overwrites one still in the stage
  `C2D_ASSERT_IMP(a_no_overwrite, in_acc && s1_vld_r, s1_adv)

endmodule
